### src/mm_pkg.sv
`timescale 1ns / 1ps
// Package for the matrix multiply block: widths, codes and the types
// shared by the controller, the datapath, the top level and the checker.
// No dependencies.
package mm_pkg;

  localparam int MAX_DIM = 8;                 // largest row/column count
  localparam int IDX_W   = 3;                 // row/column index width
  localparam int DIM_W   = 4;                 // dimension register width
  localparam int ADDR_W  = 2 * IDX_W;         // store address: {row, col}
  localparam int DEPTH   = MAX_DIM * MAX_DIM; // entries per store
  localparam int ELEM_W  = 16;                // Q8.8 element
  localparam int PROD_W  = 2 * ELEM_W;        // Q16.16 product
  localparam int ACC_W   = 35;                // exact sum of MAX_DIM products
  localparam int CFG_IDX_W = 2;

  // Item action codes
  localparam logic [1:0] ACT_WR_A    = 2'd0;
  localparam logic [1:0] ACT_WR_B    = 2'd1;
  localparam logic [1:0] ACT_COMPUTE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  typedef struct packed {
    logic [1:0]              action;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [ELEM_W-1:0] element;
  } mm_in_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] product_element;
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic                    last;
  } mm_out_t;

  typedef struct packed {
    logic [DIM_W-1:0] rows_a;
    logic [DIM_W-1:0] inner_dim;
    logic [DIM_W-1:0] cols_b;
  } mm_dims_t;

  // Tag carried alongside each multiply-accumulate
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             first;
    logic             last_k;
    logic             last_elem;
  } mm_tag_t;

  // Controller -> datapath
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             rd_valid;
    logic [IDX_W-1:0] rd_k;
    mm_tag_t          tag;
  } mm_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic pipe_active;
  } mm_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } mm_state_e;

  // Effective dimension minus one: 0 acts as 1, anything above MAX_DIM as MAX_DIM.
  function automatic logic [IDX_W-1:0] eff_m1(input logic [DIM_W-1:0] r);
    logic [DIM_W-1:0] v;
    if (r == '0) begin
      v = DIM_W'(1);
    end else if (r > DIM_W'(MAX_DIM)) begin
      v = DIM_W'(MAX_DIM);
    end else begin
      v = r;
    end
    return IDX_W'(v - DIM_W'(1));
  endfunction

endpackage

### src/matrix_multiply.sv
`timescale 1ns / 1ps
// Top level of the matrix multiply C = A x B on signed Q8.8 elements.
// Holds the dimension registers; instantiates mm_ctrl and mm_datapath (mm_pkg).
//
// Items are taken when start is high and busy is low. A write item (A or B
// element, addressed by row and column) is dropped when it lies outside the
// configured dimensions. A compute item runs one multiply-accumulate per cycle
// through a single 16x16 multiplier and holds busy until the pipeline drains;
// results come out on result_o in row-major order. Each result shows on
// result_o for exactly one cycle with strobe high and cannot be held off; the
// final one carries last.
// Results are exact Q.16 sums, 35 bits signed. Elements read by a compute
// must have been written before; the stores are not cleared by reset.
// Dimension registers (0 acts as 1, above 8 acts as 8) must be written through
// cfg_we_i / cfg_idx_i / cfg_data_i only while idle; the block does not check.
module matrix_multiply import mm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // item port
  input  logic                 start,
  input  mm_in_t               item_i,
  output logic                 busy,
  // result port
  output logic                 strobe,
  output mm_out_t              result_o,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_data_i
);

  mm_dims_t   dims_q;
  mm_cmd_t    cmd;
  mm_status_t status;

  // Dimension registers keep the bits written; clamping happens in the controller
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q.rows_a    <= DIM_W'(MAX_DIM);
      dims_q.inner_dim <= DIM_W'(MAX_DIM);
      dims_q.cols_b    <= DIM_W'(MAX_DIM);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_ROWS_A) begin
        dims_q.rows_a <= cfg_data_i;
      end else if (cfg_idx_i == REG_INNER_DIM) begin
        dims_q.inner_dim <= cfg_data_i;
      end else if (cfg_idx_i == REG_COLS_B) begin
        dims_q.cols_b <= cfg_data_i;
      end
    end
  end

  // Sequencer: write checks and the i/j/k walk
  mm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .item_i   (item_i),
    .dims_i   (dims_q),
    .status_i (status),
    .busy     (busy),
    .cmd_o    (cmd)
  );

  // Stores, read -> multiply -> accumulate, result register
  mm_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .status_o (status),
    .strobe   (strobe),
    .result_o (result_o)
  );

endmodule

### src/mm_ctrl.sv
`timescale 1ns / 1ps
// Controller for the matrix multiply: accepts items, range-checks writes and
// walks i/j/k over the result. Depends on mm_pkg.
module mm_ctrl import mm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  mm_in_t     item_i,
  input  mm_dims_t   dims_i,
  input  mm_status_t status_i,
  output logic       busy,
  output mm_cmd_t    cmd_o
);

  mm_state_e        state_q, state_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [IDX_W-1:0] nr_m1, nk_m1, nc_m1;
  logic             last_k;

  assign nr_m1  = eff_m1(dims_i.rows_a);
  assign nk_m1  = eff_m1(dims_i.inner_dim);
  assign nc_m1  = eff_m1(dims_i.cols_b);
  assign last_k = (k_q == nk_m1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    cmd_o   = '0;
    busy    = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (item_i.action == ACT_WR_A) begin
            cmd_o.wr_a = (item_i.row_index <= nr_m1) && (item_i.col_index <= nk_m1);
          end else if (item_i.action == ACT_WR_B) begin
            cmd_o.wr_b = (item_i.row_index <= nk_m1) && (item_i.col_index <= nc_m1);
          end else if (item_i.action == ACT_COMPUTE) begin
            state_d = ST_ISSUE;
            i_d     = '0;
            j_d     = '0;
            k_d     = '0;
          end
        end
      end
      ST_ISSUE: begin
        cmd_o.rd_valid      = 1'b1;
        cmd_o.rd_k          = k_q;
        cmd_o.tag.row       = i_q;
        cmd_o.tag.col       = j_q;
        cmd_o.tag.first     = (k_q == '0);
        cmd_o.tag.last_k    = last_k;
        cmd_o.tag.last_elem = last_k && (i_q == nr_m1) && (j_q == nc_m1);
        if (!last_k) begin
          k_d = k_q + IDX_W'(1);
        end else begin
          k_d = '0;
          if (j_q != nc_m1) begin
            j_d = j_q + IDX_W'(1);
          end else begin
            j_d = '0;
            if (i_q != nr_m1) begin
              i_d = i_q + IDX_W'(1);
            end else begin
              state_d = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_active) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### src/mm_datapath.sv
`timescale 1ns / 1ps
// Datapath for the matrix multiply: A and B stores, registered reads,
// a registered multiplier and the exact accumulator. Depends on mm_pkg.
module mm_datapath import mm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  mm_in_t     item_i,
  input  mm_cmd_t    cmd_i,
  output mm_status_t status_o,
  output logic       strobe,
  output mm_out_t    result_o
);

  logic signed [ELEM_W-1:0] a_mem [DEPTH];
  logic signed [ELEM_W-1:0] b_mem [DEPTH];

  logic [ADDR_W-1:0]        wr_addr, a_raddr, b_raddr;
  logic signed [ELEM_W-1:0] a_rd_q, b_rd_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_sum;
  mm_tag_t                  s1_tag_q, s2_tag_q;
  logic                     s1_v_q, s2_v_q, strobe_q;
  mm_out_t                  res_q;

  assign wr_addr = {item_i.row_index, item_i.col_index};
  assign a_raddr = {cmd_i.tag.row, cmd_i.rd_k};
  assign b_raddr = {cmd_i.rd_k, cmd_i.tag.col};

  // Stores: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a) begin
      a_mem[wr_addr] <= item_i.element;
    end
    a_rd_q <= a_mem[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_b) begin
      b_mem[wr_addr] <= item_i.element;
    end
    b_rd_q <= b_mem[b_raddr];
  end

  // first term restarts the sum
  assign acc_sum = (s2_tag_q.first ? ACC_W'(0) : acc_q) + ACC_W'(prod_q);

  always_ff @(posedge clk_i) begin
    s1_tag_q <= cmd_i.tag;
    s2_tag_q <= s1_tag_q;
    prod_q   <= PROD_W'(a_rd_q) * PROD_W'(b_rd_q);
    if (s2_v_q) begin
      acc_q <= acc_sum;
    end
    if (s2_v_q && s2_tag_q.last_k) begin
      res_q.product_element <= acc_sum;
      res_q.out_row         <= s2_tag_q.row;
      res_q.out_col         <= s2_tag_q.col;
      res_q.last            <= s2_tag_q.last_elem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      s1_v_q   <= cmd_i.rd_valid;
      s2_v_q   <= s1_v_q;
      strobe_q <= s2_v_q && s2_tag_q.last_k;
    end
  end

  assign status_o.pipe_active = s1_v_q | s2_v_q;
  assign strobe               = strobe_q;
  assign result_o             = res_q;

endmodule

### src/mm_checker.sv
`timescale 1ns / 1ps
// Port-level checker for matrix_multiply, bound to the top level.
// Depends on mm_pkg.
module mm_checker import mm_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input mm_in_t               item_i,
  input logic                 busy,
  input logic                 strobe,
  input mm_out_t              result_o,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_idx_i,
  input logic [DIM_W-1:0]     cfg_data_i
);

  // results only come out of a running compute
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> busy) else $error("result outside a compute");

  // a compute item makes the block busy
  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.action == ACT_COMPUTE) |=> busy)
    else $error("compute item not started");

  // nothing follows the final result straight away
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe && result_o.last) |=> !strobe) else $error("result after last");

  // busy only ends right after the final result
  a_end_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(strobe && result_o.last))
    else $error("compute ended without last result");

  // dimension writes land only while idle, with a known index and value
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> (!busy && !$isunknown({cfg_idx_i, cfg_data_i})))
    else $error("configuration write while busy");

endmodule

bind matrix_multiply mm_checker u_mm_checker (.*);
